FILE: hw/rtl/primitive_index_assembler_defines.svh
// Assertion macros used by the checker.
`ifndef PRIMITIVE_INDEX_ASSEMBLER_DEFINES_SVH
`define PRIMITIVE_INDEX_ASSEMBLER_DEFINES_SVH

// Checks that cons holds in the cycle after ante, outside reset.
`define PIA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pia check failed");

// Checks that cons holds in the same cycle as ante, outside reset.
`define PIA_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pia check failed");

`endif

FILE: hw/rtl/pia_pkg.sv
package pia_pkg;

   // Field widths.
   localparam int OP_W   = 2;
   localparam int MODE_W = 4;
   localparam int IDX_W  = 12;

   // Default batch capacity in vertices.
   localparam int MAX_VERTS_DEFAULT = 4096;

   // A primitive emits at most six indices (a quad as two triangles).
   localparam int JOB_SLOTS = 6;
   localparam int PTR_W     = $clog2(JOB_SLOTS);

   // Event codes.
   localparam logic [OP_W-1:0] OP_BEGIN  = 2'd0;
   localparam logic [OP_W-1:0] OP_VERTEX = 2'd1;
   localparam logic [OP_W-1:0] OP_END    = 2'd2;

   // Primitive kinds.
   localparam logic [MODE_W-1:0] MODE_LINES     = 4'd1;
   localparam logic [MODE_W-1:0] MODE_TRIANGLES = 4'd4;
   localparam logic [MODE_W-1:0] MODE_STRIP     = 4'd5;
   localparam logic [MODE_W-1:0] MODE_QUADS     = 4'd7;
   localparam logic [MODE_W-1:0] MODE_POLYGON   = 4'd9;

   // Indices of one completed primitive, handed from the front end to the emitter.
   typedef struct packed {
      logic                             emit;
      logic [PTR_W-1:0]                 last_ptr;
      logic [JOB_SLOTS-1:0][IDX_W-1:0]  idx;
   } job_type;

endpackage

FILE: hw/rtl/pia_req_if.sv
interface pia_req_if;
   import pia_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [MODE_W-1:0] prim_mode;

   modport source (output valid, output op, output prim_mode, input ready);
   modport sink   (input valid, input op, input prim_mode, output ready);
endinterface

FILE: hw/rtl/pia_rsp_if.sv
interface pia_rsp_if;
   import pia_pkg::*;

   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] vert_index;
   logic             last;

   modport source (output valid, output vert_index, output last, input ready);
   modport sink   (input valid, input vert_index, input last, output ready);
endinterface

FILE: hw/rtl/primitive_index_assembler.sv
// Primitive index assembler: takes begin, vertex and end requests and emits the
// vertex indices of each completed primitive (lines, triangles, triangle strip,
// quads or polygon fan), one index per response, with last set on the final
// index of a request. A request updates the batch state when it is taken; a
// vertex that completes a primitive then occupies the single response port
// until it has emitted its indices (two for lines, three for triangles,
// strips and polygons, six for quads), and the next request is taken in the
// same cycle as the final index is taken. Requests that emit nothing run at
// one per cycle while no response is pending. Indices are the low 12 bits
// of the position within the batch; vertices past MAX_VERTS are dropped.
module primitive_index_assembler #(
   parameter int MAX_VERTS = pia_pkg::MAX_VERTS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   pia_req_if.sink   req_port,
   pia_rsp_if.source rsp_port
);
   import pia_pkg::*;

   job_type job;
   logic    slot_free;

   pia_front #(
      .MAX_VERTS (MAX_VERTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_port  (req_port),
      .slot_free (slot_free),
      .job       (job)
   );

   pia_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .job       (job),
      .slot_free (slot_free),
      .rsp_port  (rsp_port)
   );

endmodule

FILE: hw/rtl/pia_front.sv
module pia_front #(
   parameter int MAX_VERTS = pia_pkg::MAX_VERTS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   pia_req_if.sink          req_port,
   input  logic             slot_free,
   output pia_pkg::job_type job
);
   import pia_pkg::*;

   localparam int CNT_W = $clog2(MAX_VERTS + 1);

   logic              in_batch_ff, in_batch_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [1:0]        mod3_ff, mod3_in;

   logic              accept;
   logic              counted;
   logic [CNT_W-1:0]  count_next;
   logic [1:0]        mod3_next;
   logic [IDX_W-1:0]  ci;
   logic [IDX_W-1:0]  strip_base;

   // A request is taken whenever the emitter can hold a new primitive.
   assign req_port.ready = slot_free;
   assign accept = req_port.valid && req_port.ready;

   // A vertex is counted only inside a batch and below capacity.
   assign counted = accept && (req_port.op == OP_VERTEX) && in_batch_ff &&
                    (count_ff != CNT_W'(MAX_VERTS));
   assign count_next = count_ff + 1'b1;
   assign mod3_next  = (mod3_ff == 2'd2) ? 2'd0 : mod3_ff + 2'd1;
   assign ci         = IDX_W'(count_next);
   assign strip_base = ci - IDX_W'(3);

   // Batch state update.
   always_comb begin
      in_batch_in = in_batch_ff;
      mode_in     = mode_ff;
      count_in    = count_ff;
      mod3_in     = mod3_ff;
      if (accept) begin
         case (req_port.op)
            OP_BEGIN: begin
               mode_in     = req_port.prim_mode;
               count_in    = '0;
               mod3_in     = '0;
               in_batch_in = 1'b1;
            end
            OP_END: begin
               in_batch_in = 1'b0;
               count_in    = '0;
               mod3_in     = '0;
            end
            OP_VERTEX: begin
               if (counted) begin
                  count_in = count_next;
                  mod3_in  = mod3_next;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_batch_ff <= 1'b0;
         mode_ff     <= '0;
         count_ff    <= '0;
         mod3_ff     <= '0;
      end else begin
         in_batch_ff <= in_batch_in;
         mode_ff     <= mode_in;
         count_ff    <= count_in;
         mod3_ff     <= mod3_in;
      end
   end

   // Indices of the primitive that the new vertex completes, if any.
   always_comb begin
      job.emit     = 1'b0;
      job.last_ptr = '0;
      job.idx      = '0;
      case (mode_ff)
         MODE_LINES: begin
            job.emit     = !count_next[0];
            job.last_ptr = PTR_W'(1);
            job.idx[0]   = ci - IDX_W'(2);
            job.idx[1]   = ci - IDX_W'(1);
         end
         MODE_TRIANGLES: begin
            job.emit     = (mod3_next == 2'd0);
            job.last_ptr = PTR_W'(2);
            job.idx[0]   = ci - IDX_W'(3);
            job.idx[1]   = ci - IDX_W'(2);
            job.idx[2]   = ci - IDX_W'(1);
         end
         MODE_STRIP: begin
            // Odd triangles swap their last two indices to keep the winding.
            job.emit     = (count_next >= CNT_W'(3));
            job.last_ptr = PTR_W'(2);
            job.idx[0]   = strip_base;
            if (strip_base[0]) begin
               job.idx[1] = strip_base + IDX_W'(2);
               job.idx[2] = strip_base + IDX_W'(1);
            end else begin
               job.idx[1] = strip_base + IDX_W'(1);
               job.idx[2] = strip_base + IDX_W'(2);
            end
         end
         MODE_QUADS: begin
            job.emit     = (count_next[1:0] == 2'd0);
            job.last_ptr = PTR_W'(5);
            job.idx[0]   = ci - IDX_W'(4);
            job.idx[1]   = ci - IDX_W'(3);
            job.idx[2]   = ci - IDX_W'(2);
            job.idx[3]   = ci - IDX_W'(4);
            job.idx[4]   = ci - IDX_W'(2);
            job.idx[5]   = ci - IDX_W'(1);
         end
         MODE_POLYGON: begin
            // Fan around the first vertex of the batch.
            job.emit     = (count_next >= CNT_W'(3));
            job.last_ptr = PTR_W'(2);
            job.idx[0]   = '0;
            job.idx[1]   = ci - IDX_W'(2);
            job.idx[2]   = ci - IDX_W'(1);
         end
         default: begin
         end
      endcase
      job.emit = job.emit && counted;
   end

endmodule

FILE: hw/rtl/pia_emit.sv
module pia_emit (
   input  logic             clock,
   input  logic             reset,
   input  pia_pkg::job_type job,
   output logic             slot_free,
   pia_rsp_if.source        rsp_port
);
   import pia_pkg::*;

   job_type          job_ff;
   logic             valid_ff, valid_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic             at_last;
   logic             taken;

   assign at_last = (ptr_ff == job_ff.last_ptr);
   assign taken   = valid_ff && rsp_port.ready;

   // The slot frees up in the cycle its final index is taken.
   assign slot_free = !valid_ff || (taken && at_last);

   assign rsp_port.valid      = valid_ff;
   assign rsp_port.vert_index = job_ff.idx[ptr_ff];
   assign rsp_port.last       = at_last;

   // Walk through the held primitive one index per cycle while the response port is ready.
   always_comb begin
      valid_in = valid_ff;
      ptr_in   = ptr_ff;
      if (slot_free && job.emit) begin
         valid_in = 1'b1;
         ptr_in   = '0;
      end else if (taken) begin
         if (at_last) begin
            valid_in = 1'b0;
         end else begin
            ptr_in = ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ptr_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         ptr_ff   <= ptr_in;
      end
   end

   // Payload register, loaded when a new primitive arrives.
   always_ff @(posedge clock) begin
      if (slot_free && job.emit) begin
         job_ff <= job;
      end
   end

endmodule

FILE: hw/rtl/pia_checker.sv
`include "primitive_index_assembler_defines.svh"

module pia_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic [pia_pkg::OP_W-1:0] req_op,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic                     rsp_last,
   input logic [pia_pkg::IDX_W-1:0] rsp_vert_index
);
   import pia_pkg::*;

   // A stalled response keeps its index and marker.
   `PIA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_vert_index) && $stable(rsp_last))

   // With no response pending, a request is always taken.
   `PIA_ASSERT_SAME(a_idle_ready, !rsp_valid, req_ready)

   // Begin, end and unknown requests never start a response.
   `PIA_ASSERT_NEXT(a_no_spurious, req_valid && req_ready && req_op != OP_VERTEX && !rsp_valid, !rsp_valid)

   // A primitive's indices come out without a gap until the last one.
   `PIA_ASSERT_NEXT(a_no_gap, rsp_valid && rsp_ready && !rsp_last, rsp_valid)

endmodule

bind primitive_index_assembler pia_checker u_pia_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_port.valid),
   .req_ready      (req_port.ready),
   .req_op         (req_port.op),
   .rsp_valid      (rsp_port.valid),
   .rsp_ready      (rsp_port.ready),
   .rsp_last       (rsp_port.last),
   .rsp_vert_index (rsp_port.vert_index)
);
